FILE: hw/rtl/v2xpc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2xpc_pkg
// shared types and constants of the v2x message plausibility check
// ----------------------------------------------------------------------------

package v2xpc_pkg;

	localparam int unsigned CFG_INDEX_W = 3;
	localparam int unsigned CFG_DATA_W  = 32;

	// configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCKED_A      = 3'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCKED_B      = 3'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCKED_C      = 3'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCKED_D      = 3'd3;
	localparam logic [CFG_INDEX_W-1:0] REG_POSITION_LIMIT = 3'd4;
	localparam logic [CFG_INDEX_W-1:0] REG_SPEED_LIMIT    = 3'd5;

	// register reset values
	localparam logic [31:0] BLOCKED_A_RST      = 32'd2000;
	localparam logic [31:0] BLOCKED_B_RST      = 32'd35000;
	localparam logic [31:0] BLOCKED_C_RST      = 32'd23000;
	localparam logic [31:0] BLOCKED_D_RST      = 32'd11000;
	localparam logic [23:0] POSITION_LIMIT_RST = 24'd800;
	localparam logic [15:0] SPEED_LIMIT_RST    = 16'd640;

	typedef struct packed {
		logic [31:0]        sender_address;
		logic signed [23:0] report_x;
		logic signed [23:0] report_y;
		logic [15:0]        report_speed;
	} in_item_t;

	typedef struct packed {
		logic        listed_sender;
		logic        deviant;
		logic [31:0] detected_count;
	} out_item_t;

	// one ring entry
	typedef struct packed {
		logic signed [23:0] x;
		logic signed [23:0] y;
		logic [15:0]        speed;
	} hist_entry_t;

endpackage

FILE: hw/rtl/v2xpc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2xpc_div
// shared restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------

module v2xpc_div #(
	parameter int unsigned DW = 28,
	parameter int unsigned CW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [CW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quotient
);

	localparam int unsigned CNT_W = $clog2(DW + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DW-1:0]    quot_q;
	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    divisor_q;
	logic [CW:0]      shifted;
	logic [CW:0]      diff;
	logic             ge;

	// shift in the next dividend bit and try the subtraction
	assign shifted = {rem_q, quot_q[DW-1]};
	assign diff    = shifted - {1'b0, divisor_q};
	assign ge      = (shifted >= {1'b0, divisor_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quot_q    <= dividend;
			rem_q     <= '0;
			divisor_q <= divisor;
		end else if (busy_q) begin
			quot_q <= {quot_q[DW-2:0], ge};
			rem_q  <= ge ? diff[CW-1:0] : shifted[CW-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quot_q;

endmodule

FILE: hw/rtl/v2xpc_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2xpc_hist
// ring memory of past reports, one write and one registered read port
// ----------------------------------------------------------------------------

module v2xpc_hist #(
	parameter int unsigned DEPTH = 16,
	parameter int unsigned AW    = 4
) (
	input  logic                   clk,
	input  logic                   wr_en,
	input  logic [AW-1:0]          wr_addr,
	input  v2xpc_pkg::hist_entry_t wr_data,
	input  logic                   rd_en,
	input  logic [AW-1:0]          rd_addr,
	output v2xpc_pkg::hist_entry_t rd_data
);

	v2xpc_pkg::hist_entry_t mem_q [DEPTH];
	v2xpc_pkg::hist_entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// read data holds until the next read
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: hw/rtl/v2x_message_plausibility_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// v2x_message_plausibility_check
// flags messages from blocklisted senders and reports that stray too far
// from the mean of the recent history, with a saturating detection count
// ----------------------------------------------------------------------------
// sequence: a blocklisted sender goes straight to the verdict, an empty
//   history straight to the ring update, otherwise means, distances, compare
// throughput: one transaction at a time, no accept until back in idle, which
//   a stalled output delays; the three mean divisions on the shared divider set it
// reset: asynchronous, clears control state, registers to their reset
//   values, history empty and count zero; ring contents are not cleared
// ----------------------------------------------------------------------------

module v2x_message_plausibility_check #(
	parameter int unsigned HISTORY_DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     arst_n,
	// configuration write port
	input  logic                                     cfg_write,
	input  logic [v2xpc_pkg::CFG_INDEX_W-1:0]        cfg_index,
	input  logic [v2xpc_pkg::CFG_DATA_W-1:0]         cfg_data,
	// message input
	input  logic                                     in_valid,
	output logic                                     in_stall,
	input  v2xpc_pkg::in_item_t                      in_data,
	// verdict output
	output logic                                     out_valid,
	input  logic                                     out_stall,
	output v2xpc_pkg::out_item_t                     out_data
);

	// widths that follow from the history depth
	localparam int unsigned SLOT_W = $clog2(HISTORY_DEPTH);
	localparam int unsigned FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int unsigned SXW    = 24 + $clog2(HISTORY_DEPTH);  // position sums
	localparam int unsigned SSW    = 16 + $clog2(HISTORY_DEPTH);  // speed sum

	// sequencer states, one-hot
	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_DIV_X  = 10'b00_0000_0010,
		ST_DIV_Y  = 10'b00_0000_0100,
		ST_DIV_S  = 10'b00_0000_1000,
		ST_MUL_X  = 10'b00_0001_0000,
		ST_MUL_Y  = 10'b00_0010_0000,
		ST_MUL_L  = 10'b00_0100_0000,
		ST_CMP    = 10'b00_1000_0000,
		ST_UPDATE = 10'b01_0000_0000,
		ST_FIN    = 10'b10_0000_0000
	} state_t;

	state_t state_q;

	// configuration registers
	logic [31:0] blocked_a_q;
	logic [31:0] blocked_b_q;
	logic [31:0] blocked_c_q;
	logic [31:0] blocked_d_q;
	logic [23:0] position_limit_q;
	logic [15:0] speed_limit_q;

	// history bookkeeping
	logic signed [SXW-1:0] sum_x_q;
	logic signed [SXW-1:0] sum_y_q;
	logic [SSW-1:0]        sum_s_q;
	logic [FILL_W-1:0]     fill_q;
	logic [SLOT_W-1:0]     slot_q;
	logic [31:0]           flag_total_q;

	// per-transaction working registers
	v2xpc_pkg::in_item_t   item_q;
	logic                  listed_q;
	logic                  dev_q;
	logic                  div_run_q;
	logic signed [24:0]    mean_x_q;
	logic signed [24:0]    mean_y_q;
	logic [15:0]           mean_s_q;
	logic [23:0]           dx_q;
	logic [23:0]           dy_q;
	logic [15:0]           ds_q;
	logic [47:0]           prod_q;
	logic [48:0]           d2_q;

	// output register
	logic                  out_valid_q;
	v2xpc_pkg::out_item_t  out_data_q;

	// handshake
	logic in_accept;
	logic out_free;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_accept = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;

	// blocklist match on the incoming address
	logic listed_in;
	assign listed_in = (in_data.sender_address == blocked_a_q) ||
	                   (in_data.sender_address == blocked_b_q) ||
	                   (in_data.sender_address == blocked_c_q) ||
	                   (in_data.sender_address == blocked_d_q);

	logic ring_full;
	assign ring_full = (fill_q == FILL_W'(HISTORY_DEPTH));

	// ------------------------------------------------------------------------
	// configuration writes
	// ------------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_a_q      <= v2xpc_pkg::BLOCKED_A_RST;
			blocked_b_q      <= v2xpc_pkg::BLOCKED_B_RST;
			blocked_c_q      <= v2xpc_pkg::BLOCKED_C_RST;
			blocked_d_q      <= v2xpc_pkg::BLOCKED_D_RST;
			position_limit_q <= v2xpc_pkg::POSITION_LIMIT_RST;
			speed_limit_q    <= v2xpc_pkg::SPEED_LIMIT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				v2xpc_pkg::REG_BLOCKED_A:      blocked_a_q      <= cfg_data;
				v2xpc_pkg::REG_BLOCKED_B:      blocked_b_q      <= cfg_data;
				v2xpc_pkg::REG_BLOCKED_C:      blocked_c_q      <= cfg_data;
				v2xpc_pkg::REG_BLOCKED_D:      blocked_d_q      <= cfg_data;
				v2xpc_pkg::REG_POSITION_LIMIT: position_limit_q <= cfg_data[23:0];
				v2xpc_pkg::REG_SPEED_LIMIT:    speed_limit_q    <= cfg_data[15:0];
				default: ;  // unknown index, write dropped
			endcase
		end
	end

	// ------------------------------------------------------------------------
	// shared divider: one mean after another, magnitude divided, sign restored
	// ------------------------------------------------------------------------
	logic              div_start;
	logic              div_done;
	logic [SXW-1:0]    div_dividend;
	logic [SXW-1:0]    div_quot;
	logic [SXW-1:0]    mag_x;
	logic [SXW-1:0]    mag_y;

	assign mag_x = sum_x_q[SXW-1] ? SXW'(-sum_x_q) : SXW'(sum_x_q);
	assign mag_y = sum_y_q[SXW-1] ? SXW'(-sum_y_q) : SXW'(sum_y_q);

	always_comb begin
		div_dividend = '0;
		case (state_q)
			ST_DIV_X: div_dividend = mag_x;
			ST_DIV_Y: div_dividend = mag_y;
			ST_DIV_S: div_dividend = SXW'(sum_s_q);
			default:  div_dividend = '0;
		endcase
	end

	assign div_start = !div_run_q &&
	                   (state_q == ST_DIV_X || state_q == ST_DIV_Y || state_q == ST_DIV_S);

	v2xpc_div #(
		.DW (SXW),
		.CW (FILL_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (fill_q),
		.done     (div_done),
		.quotient (div_quot)
	);

	// mean magnitudes stay within 24 bits
	logic signed [24:0] quot_pos;
	assign quot_pos = $signed({1'b0, div_quot[23:0]});

	// ------------------------------------------------------------------------
	// history ring
	// ------------------------------------------------------------------------
	logic                   hist_wr_en;
	v2xpc_pkg::hist_entry_t hist_wr_data;
	v2xpc_pkg::hist_entry_t hist_old;

	assign hist_wr_en         = (state_q == ST_UPDATE);
	assign hist_wr_data.x     = item_q.report_x;
	assign hist_wr_data.y     = item_q.report_y;
	assign hist_wr_data.speed = item_q.report_speed;

	// the oldest slot is read at accept, needed only once the ring is full
	v2xpc_hist #(
		.DEPTH (HISTORY_DEPTH),
		.AW    (SLOT_W)
	) u_hist (
		.clk     (clk),
		.wr_en   (hist_wr_en),
		.wr_addr (slot_q),
		.wr_data (hist_wr_data),
		.rd_en   (in_accept),
		.rd_addr (slot_q),
		.rd_data (hist_old)
	);

	// ------------------------------------------------------------------------
	// distance terms and the shared squarer
	// ------------------------------------------------------------------------
	function automatic logic [23:0] abs_diff25(logic signed [24:0] a, logic signed [24:0] b);
		logic signed [25:0] d;
		d = {a[24], a} - {b[24], b};
		return d[25] ? 24'(-d) : d[23:0];
	endfunction

	logic [23:0] mul_a;

	always_comb begin
		mul_a = '0;
		case (state_q)
			ST_MUL_X: mul_a = dx_q;
			ST_MUL_Y: mul_a = dy_q;
			ST_MUL_L: mul_a = position_limit_q;
			default:  mul_a = '0;
		endcase
	end

	// differences track their means, settled long before the squarer needs them
	always_ff @(posedge clk) begin
		dx_q   <= abs_diff25(25'($signed(item_q.report_x)), mean_x_q);
		dy_q   <= abs_diff25(25'($signed(item_q.report_y)), mean_y_q);
		ds_q   <= (item_q.report_speed >= mean_s_q) ? item_q.report_speed - mean_s_q
		                                            : mean_s_q - item_q.report_speed;
		prod_q <= mul_a * mul_a;
	end

	// ------------------------------------------------------------------------
	// sequencer
	// ------------------------------------------------------------------------
	logic [31:0] count_next;
	assign count_next = ((listed_q || dev_q) && (flag_total_q != '1)) ? flag_total_q + 32'd1
	                                                                    : flag_total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			div_run_q    <= 1'b0;
			sum_x_q      <= '0;
			sum_y_q      <= '0;
			sum_s_q      <= '0;
			fill_q       <= '0;
			slot_q       <= '0;
			flag_total_q <= '0;
			out_valid_q  <= 1'b0;
			listed_q     <= 1'b0;
			dev_q        <= 1'b0;
		end else begin
			// a new verdict loads the output register, otherwise it empties when taken
			if (state_q == ST_FIN && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						listed_q <= listed_in;
						dev_q    <= 1'b0;
						if (listed_in) begin
							state_q <= ST_FIN;
						end else if (fill_q == '0) begin
							state_q <= ST_UPDATE;
						end else begin
							state_q <= ST_DIV_X;
						end
					end
				end
				ST_DIV_X: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						state_q   <= ST_DIV_Y;
					end
				end
				ST_DIV_Y: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						state_q   <= ST_DIV_S;
					end
				end
				ST_DIV_S: begin
					if (!div_run_q) begin
						div_run_q <= 1'b1;
					end else if (div_done) begin
						div_run_q <= 1'b0;
						state_q   <= ST_MUL_X;
					end
				end
				ST_MUL_X: state_q <= ST_MUL_Y;
				ST_MUL_Y: state_q <= ST_MUL_L;
				ST_MUL_L: state_q <= ST_CMP;
				ST_CMP: begin
					// strictly greater on both limits
					dev_q   <= (d2_q > {1'b0, prod_q}) || (ds_q > speed_limit_q);
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					// oldest entry leaves the sums when the ring wraps
					if (ring_full) begin
						sum_x_q <= sum_x_q + SXW'($signed(item_q.report_x))
						                   - SXW'($signed(hist_old.x));
						sum_y_q <= sum_y_q + SXW'($signed(item_q.report_y))
						                   - SXW'($signed(hist_old.y));
						sum_s_q <= sum_s_q + SSW'(item_q.report_speed)
						                   - SSW'(hist_old.speed);
					end else begin
						sum_x_q <= sum_x_q + SXW'($signed(item_q.report_x));
						sum_y_q <= sum_y_q + SXW'($signed(item_q.report_y));
						sum_s_q <= sum_s_q + SSW'(item_q.report_speed);
						fill_q  <= fill_q + 1'b1;
					end
					slot_q  <= (slot_q == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : slot_q + 1'b1;
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					// hold the verdict until the output register is free
					if (out_free) begin
						flag_total_q <= count_next;
						state_q      <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload side of the sequencer
	always_ff @(posedge clk) begin
		if (in_accept) begin
			item_q <= in_data;
		end
		if (div_done) begin
			case (state_q)
				ST_DIV_X: mean_x_q <= sum_x_q[SXW-1] ? -quot_pos : quot_pos;
				ST_DIV_Y: mean_y_q <= sum_y_q[SXW-1] ? -quot_pos : quot_pos;
				ST_DIV_S: mean_s_q <= div_quot[15:0];
				default: ;
			endcase
		end
		case (state_q)
			ST_MUL_Y: d2_q <= {1'b0, prod_q};
			ST_MUL_L: d2_q <= d2_q + {1'b0, prod_q};
			default: ;
		endcase
		if (state_q == ST_FIN && out_free) begin
			out_data_q.listed_sender  <= listed_q;
			out_data_q.deviant        <= dev_q;
			out_data_q.detected_count <= count_next;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule
